[rtl/core/scba_pkg.sv]
// Shared types, constants and helper functions for the size-class block allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

    // Allocator geometry.
    localparam int MIN_BLOCK   = 16;
    localparam int NUM_CLASSES = 12;
    localparam int STACK_DEPTH = 64;

    // Field widths of the channels.
    localparam int OP_W   = 2;
    localparam int SIZE_W = 17;
    localparam int OFF_W  = 16;
    localparam int ST_W   = 3;

    // Derived widths. A class number must also hold NUM_CLASSES (oversize).
    localparam int CLASS_W   = $clog2(NUM_CLASSES + 1);
    localparam int CIDX_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CMP_W     = SIZE_W + NUM_CLASSES + 11;

    localparam logic [SIZE_W-1:0] ARENA_MAX = SIZE_W'(65536);

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;
    typedef logic [1:0]      t_res_src;

    localparam t_op OP_ALLOC   = 2'd0;
    localparam t_op OP_RELEASE = 2'd1;
    localparam t_op OP_GROW    = 2'd2;
    localparam t_op OP_NONE    = 2'd3;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_NOCHANGE  = 3'd1;
    localparam t_status ST_TOOLARGE  = 3'd2;
    localparam t_status ST_EXHAUSTED = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    // Where the offset and capacity of a result come from.
    localparam t_res_src RES_ZERO = 2'd0;
    localparam t_res_src RES_OLD  = 2'd1;
    localparam t_res_src RES_BUMP = 2'd2;
    localparam t_res_src RES_POP  = 2'd3;

    typedef struct packed {
        logic     sel_cap;   // stack ops use the class of the old block
        logic     pop;
        logic     push;
        logic     bump;
        logic     set_res;
        t_res_src res_src;
        logic     set_st;
        t_status  res_st;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic req_over;
        logic cap_zero;
        logic cap_over;
        logic fits;
        logic fill_empty;
        logic fill_full;
        logic arena_ok;
        logic out_free;
    } t_dp_stat;

    // Smallest class that holds x; NUM_CLASSES when none does. The compares
    // are independent, and since they are monotonic their count is the class.
    function automatic logic [CLASS_W-1:0] size_class(input logic [SIZE_W-1:0] x);
        logic [CLASS_W-1:0] c;
        c = '0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if ((CMP_W'(MIN_BLOCK) << k) < CMP_W'(x)) begin
                c = c + CLASS_W'(1);
            end
        end
        return c;
    endfunction

    function automatic logic [SIZE_W-1:0] class_size(input logic [CLASS_W-1:0] c);
        return SIZE_W'(MIN_BLOCK) << c;
    endfunction

    function automatic logic [ADDR_W-1:0] stack_addr(input logic [CIDX_W-1:0] cls,
                                                     input logic [SLOT_W-1:0] slot);
        return ADDR_W'(int'(cls) * STACK_DEPTH + int'(slot));
    endfunction

endpackage

`default_nettype wire

[rtl/core/scba_if.sv]
// Valid/ready channel interfaces of the allocator: request, response and configuration.
// Field widths come from scba_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface scba_req_if import scba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  block_offset;
    logic [SIZE_W-1:0] block_capacity;

    modport source (output valid, output operation, output request_size,
                    output block_offset, output block_capacity, input ready);
    modport sink   (input valid, input operation, input request_size,
                    input block_offset, input block_capacity, output ready);
endinterface

interface scba_rsp_if import scba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OFF_W-1:0]  result_offset;
    logic [SIZE_W-1:0] result_capacity;
    logic [ST_W-1:0]   status;

    modport source (output valid, output result_offset, output result_capacity,
                    output status, input ready);
    modport sink   (input valid, input result_offset, input result_capacity,
                    input status, output ready);
endinterface

interface scba_cfg_if import scba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] arena_limit;

    modport source (output valid, output arena_limit, input ready);
    modport sink   (input valid, input arena_limit, output ready);
endinterface

`default_nettype wire

[rtl/core/scba_ctrl.sv]
// Controller state machine of the allocator: sequences evaluation, stack pop,
// push of the old block and loading of the response register. Uses scba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scba_ctrl import scba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EVAL    = 3'd1;
    localparam logic [2:0] S_POPWAIT = 3'd2;
    localparam logic [2:0] S_GIVE    = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.sel_cap = (r_state == S_GIVE) || (i_stat.op == OP_RELEASE);
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                unique case (i_stat.op)
                    OP_ALLOC: begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_src = RES_ZERO;
                        priority if (i_stat.req_over) begin
                            o_cmd.res_st = ST_TOOLARGE;
                        end else if (!i_stat.fill_empty) begin
                            o_cmd.set_res = 1'b0;
                            o_cmd.pop     = 1'b1;
                            n_state       = S_POPWAIT;
                        end else if (i_stat.arena_ok) begin
                            o_cmd.bump    = 1'b1;
                            o_cmd.res_src = RES_BUMP;
                            o_cmd.res_st  = ST_OK;
                        end else begin
                            o_cmd.res_st = ST_EXHAUSTED;
                        end
                    end
                    OP_RELEASE: begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_src = RES_ZERO;
                        priority if (i_stat.cap_zero) begin
                            o_cmd.res_st = ST_NOCHANGE;
                        end else if (i_stat.cap_over) begin
                            o_cmd.res_st = ST_TOOLARGE;
                        end else if (i_stat.fill_full) begin
                            o_cmd.res_st = ST_FULL;
                        end else begin
                            o_cmd.push   = 1'b1;
                            o_cmd.res_st = ST_OK;
                        end
                    end
                    OP_GROW: begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_src = RES_OLD;
                        priority if (i_stat.fits) begin
                            o_cmd.res_st = ST_NOCHANGE;
                        end else if (i_stat.req_over) begin
                            o_cmd.res_st = ST_TOOLARGE;
                        end else if (!i_stat.fill_empty) begin
                            o_cmd.set_res = 1'b0;
                            o_cmd.pop     = 1'b1;
                            n_state       = S_POPWAIT;
                        end else if (i_stat.arena_ok) begin
                            o_cmd.bump    = 1'b1;
                            o_cmd.res_src = RES_BUMP;
                            o_cmd.res_st  = ST_OK;
                            n_state       = S_GIVE;
                        end else begin
                            o_cmd.res_st = ST_EXHAUSTED;
                        end
                    end
                    default: begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_src = RES_ZERO;
                        o_cmd.res_st  = ST_NOCHANGE;
                    end
                endcase
            end
            S_POPWAIT: begin
                // The popped offset is in the stack read register now.
                o_cmd.set_res = 1'b1;
                o_cmd.res_src = RES_POP;
                o_cmd.res_st  = ST_OK;
                n_state       = (i_stat.op == OP_GROW) ? S_GIVE : S_DONE;
            end
            S_GIVE: begin
                // Free the old block of a grow; a drop shows as a full stack.
                n_state = S_DONE;
                priority if (i_stat.cap_zero) begin
                    o_cmd.set_st = 1'b0;
                end else if (i_stat.cap_over || i_stat.fill_full) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.res_st = ST_FULL;
                end else begin
                    o_cmd.push = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/core/scba_dp.sv]
// Datapath of the allocator: request registers, class logic, arena top, limit register,
// per-class fill counts, the free-stack memory and the response register. Uses scba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scba_dp import scba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_capture,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [SIZE_W-1:0] i_request_size,
    input  logic [OFF_W-1:0]  i_block_offset,
    input  logic [SIZE_W-1:0] i_block_capacity,
    input  logic              i_cfg_valid,
    input  logic [SIZE_W-1:0] i_cfg_data,
    output logic              o_cfg_ready,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [OFF_W-1:0]  o_result_offset,
    output logic [SIZE_W-1:0] o_result_capacity,
    output logic [ST_W-1:0]   o_status
);

    // Request registers.
    t_op                r_op;
    logic [OFF_W-1:0]   r_boff;
    logic [SIZE_W-1:0]  r_bcap;
    logic [CLASS_W-1:0] r_req_cls;
    logic [CLASS_W-1:0] r_cap_cls;
    logic               r_fits;

    // Allocator state.
    logic [SIZE_W-1:0]  r_limit;
    logic [SIZE_W-1:0]  r_top;
    logic [FILL_W-1:0]  r_fill [NUM_CLASSES];
    logic [OFF_W-1:0]   r_mem [MEM_DEPTH];
    logic [OFF_W-1:0]   r_mem_q;

    // Working result and response register.
    logic [OFF_W-1:0]   r_res_off;
    logic [SIZE_W-1:0]  r_res_cap;
    t_status            r_res_st;
    logic               r_out_valid;
    logic [OFF_W-1:0]   r_out_off;
    logic [SIZE_W-1:0]  r_out_cap;
    t_status            r_out_st;

    logic [CLASS_W-1:0] w_sel_cls;
    logic [CIDX_W-1:0]  w_sel_idx;
    logic [FILL_W-1:0]  w_fill;
    logic [FILL_W-1:0]  w_fill_dec;
    logic [SIZE_W-1:0]  w_csize;
    logic [SIZE_W-1:0]  w_lim;
    logic [SIZE_W:0]    w_top_end;
    logic               w_out_free;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_sel_cls  = i_cmd.sel_cap ? r_cap_cls : r_req_cls;
        // An oversize class never reaches a stack op; clamp so the index stays in range.
        w_sel_idx  = (w_sel_cls >= CLASS_W'(NUM_CLASSES)) ? '0 : w_sel_cls[CIDX_W-1:0];
        w_fill     = r_fill[w_sel_idx];
        w_fill_dec = w_fill - FILL_W'(1);
        w_csize    = class_size(r_req_cls);
        w_lim      = (r_limit > ARENA_MAX) ? ARENA_MAX : r_limit;
        w_top_end  = {1'b0, r_top} + {1'b0, w_csize};
        w_out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.req_over   = (r_req_cls >= CLASS_W'(NUM_CLASSES));
        o_stat.cap_zero   = (r_bcap == '0);
        o_stat.cap_over   = (r_cap_cls >= CLASS_W'(NUM_CLASSES));
        o_stat.fits       = r_fits;
        o_stat.fill_empty = (w_fill == '0);
        o_stat.fill_full  = (w_fill >= FILL_W'(STACK_DEPTH));
        o_stat.arena_ok   = (w_top_end <= {1'b0, w_lim});
        o_stat.out_free   = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_op      <= i_operation;
            r_boff    <= i_block_offset;
            r_bcap    <= i_block_capacity;
            r_req_cls <= size_class(i_request_size);
            r_cap_cls <= size_class(i_block_capacity);
            r_fits    <= (i_request_size <= i_block_capacity);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ARENA_MAX;
            r_top   <= '0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_fill[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.bump) begin
                r_top <= w_top_end[SIZE_W-1:0];
            end
            if (i_cmd.pop) begin
                r_fill[w_sel_idx] <= w_fill_dec;
            end else if (i_cmd.push) begin
                r_fill[w_sel_idx] <= w_fill + FILL_W'(1);
            end
        end
    end

    // Free-stack memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[stack_addr(w_sel_idx, w_fill[SLOT_W-1:0])] <= r_boff;
        end
        if (i_cmd.pop) begin
            r_mem_q <= r_mem[stack_addr(w_sel_idx, w_fill_dec[SLOT_W-1:0])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            unique case (i_cmd.res_src)
                RES_ZERO: begin
                    r_res_off <= '0;
                    r_res_cap <= '0;
                end
                RES_OLD: begin
                    r_res_off <= r_boff;
                    r_res_cap <= r_bcap;
                end
                RES_BUMP: begin
                    r_res_off <= r_top[OFF_W-1:0];
                    r_res_cap <= w_csize;
                end
                RES_POP: begin
                    r_res_off <= r_mem_q;
                    r_res_cap <= w_csize;
                end
            endcase
        end
        if (i_cmd.set_res || i_cmd.set_st) begin
            r_res_st <= i_cmd.res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_off <= r_res_off;
            r_out_cap <= r_res_cap;
            r_out_st  <= r_res_st;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_offset   = r_out_off;
    assign o_result_capacity = r_out_cap;
    assign o_status          = r_out_st;

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (w_fill != '0))
        else $error("pop issued on an empty free stack");

    a_push_nonfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (w_fill < FILL_W'(STACK_DEPTH)))
        else $error("push issued on a full free stack");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> w_out_free)
        else $error("response register overwritten before its beat was taken");

    a_pop_push_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> !i_cmd.push || $past(i_cmd.sel_cap) != i_cmd.sel_cap ||
            $past(w_sel_idx) == w_sel_idx)
        else $error("push followed a pop without the registered read data");

    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !i_cmd.load_out) |=> !r_out_valid)
        else $error("response beat taken but valid stayed high");
`endif

endmodule

`default_nettype wire

[rtl/core/size_class_block_allocator_top.sv]
// Top level of the size-class block allocator: controller and datapath joined by
// command and status structs. Depends on scba_pkg, scba_if, scba_ctrl and scba_dp.
`timescale 1ns / 1ps
`default_nettype none

// Power-of-two size-class allocator. Each request beat is rounded to the smallest
// class of 16 << c entries; allocation pops that class's free stack or bumps the
// arena top, release pushes the block, grow allocates and then frees the old block.
// One request is handled at a time; the response waits in an output register, so
// the next request beat is taken while the previous response beat is still pending.
// A grow whose request fits the old block returns it unchanged. Each request goes
// from S_EVAL to S_DONE, passing S_POPWAIT when it pops a free stack and S_GIVE,
// to free the old block, when a grow takes a new one; S_DONE waits for the output
// register to drain. The order is set by the single-port free-stack memory with
// its registered read: a pop and the push of a grow's old block use separate
// cycles. The arena limit register may be written at any time the block is idle.

module size_class_block_allocator_top import scba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scba_req_if.sink    i_req,
    scba_rsp_if.source  o_rsp,
    scba_cfg_if.sink    i_cfg
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_req_ready;
    logic     w_cfg_ready;
    logic     w_accept;

    assign i_req.ready = w_req_ready;
    assign i_cfg.ready = w_cfg_ready;
    assign w_accept    = i_req.valid && w_req_ready;

    scba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    scba_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_capture         (w_accept),
        .i_operation       (i_req.operation),
        .i_request_size    (i_req.request_size),
        .i_block_offset    (i_req.block_offset),
        .i_block_capacity  (i_req.block_capacity),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_data        (i_cfg.arena_limit),
        .o_cfg_ready       (w_cfg_ready),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_out_valid       (o_rsp.valid),
        .i_out_ready       (o_rsp.ready),
        .o_result_offset   (o_rsp.result_offset),
        .o_result_capacity (o_rsp.result_capacity),
        .o_status          (o_rsp.status)
    );

endmodule

`default_nettype wire
